[hdl/mrms_pkg.sv]
`timescale 1ns / 1ps
// mrms_pkg: shared widths, constants and controller/datapath interface structs
// for the multichannel RMS meter. No dependencies.
package mrms_pkg;

    localparam int NUM_CH      = 16;
    localparam int CH_BITS     = 4;
    localparam int ACT_BITS    = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int SQ_BITS     = 32;
    localparam int SUM_BITS    = 52;
    localparam int COUNT_BITS  = 20;
    localparam int DVD_BITS    = SUM_BITS + 16;
    localparam int ROOT_BITS   = 48;
    localparam int CNT_BITS    = 7;

    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(DVD_BITS - 1);
    localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(ROOT_BITS / 2 - 1);
    localparam logic [CNT_BITS-1:0] FRAC_LAST = CNT_BITS'(31);

    localparam logic [SAMPLE_BITS-1:0] RMS_FULL = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] RMS_LO   = 24'd83886;
    localparam logic [DVD_BITS-1:0]    Q_OVF    = DVD_BITS'((64'd1 << 30) + 64'd1) << 16;
    localparam logic [13:0]            HALF_LOG10_2 = 14'd9864;
    localparam logic [7:0]             C_MIN    = 8'd26;
    localparam logic [7:0]             C_MAX    = 8'd230;

    // register map, indexed by paddr[2]
    localparam logic REG_CHANNELS = 1'b0;
    localparam logic REG_CONTRAST = 1'b1;

    typedef struct packed {
        logic               capture;
        logic               square;
        logic               acc;
        logic               div_init;
        logic               div_step;
        logic               root_init;
        logic               root_step;
        logic               rms_load;
        logic               norm_init;
        logic               norm_step;
        logic               frac_mul;
        logic               frac_upd;
        logic               lvl_a;
        logic               lvl_b;
        logic               out_load;
        logic               clear_all;
        logic               last;
        logic [CH_BITS-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic norm_done;
        logic out_free;
    } status_t;

endpackage

[hdl/mrms_ctrl.sv]
`timescale 1ns / 1ps
// mrms_ctrl: sequencer for the RMS meter; drives mrms_dp through cmd_t.
// Depends on mrms_pkg.
module mrms_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_opcode,
    output logic                          s_ready,
    input  logic [mrms_pkg::ACT_BITS-1:0] act,
    input  mrms_pkg::status_t             status,
    output mrms_pkg::cmd_t                cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQ    = 14'b00000000000010,
        ST_ACC   = 14'b00000000000100,
        ST_START = 14'b00000000001000,
        ST_DIV   = 14'b00000000010000,
        ST_ROOTI = 14'b00000000100000,
        ST_ROOT  = 14'b00000001000000,
        ST_RMS   = 14'b00000010000000,
        ST_NORMI = 14'b00000100000000,
        ST_NORM  = 14'b00001000000000,
        ST_FRAC  = 14'b00010000000000,
        ST_LVLA  = 14'b00100000000000,
        ST_LVLB  = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } state_t;

    state_t                             state_reg, state_next;
    logic [mrms_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [mrms_pkg::CH_BITS-1:0]       ch_reg, ch_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        ch_next    = ch_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.last   = ({1'b0, ch_reg} == act - 1'b1);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_opcode) begin
                        ch_next    = '0;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_START: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == mrms_pkg::DIV_LAST) state_next = ST_ROOTI;
            end
            ST_ROOTI: begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == mrms_pkg::ROOT_LAST) state_next = ST_RMS;
            end
            ST_RMS: begin
                cmd.rms_load = 1'b1;
                state_next   = ST_NORMI;
            end
            ST_NORMI: begin
                cmd.norm_init = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM: begin
                cnt_next = '0;
                if (status.norm_done) state_next = ST_FRAC;
                else cmd.norm_step = 1'b1;
            end
            ST_FRAC: begin
                // even count: square, odd count: renormalize and take a bit
                if (cnt_reg[0]) cmd.frac_upd = 1'b1;
                else cmd.frac_mul = 1'b1;
                if (cnt_reg == mrms_pkg::FRAC_LAST) state_next = ST_LVLA;
            end
            ST_LVLA: begin
                cmd.lvl_a  = 1'b1;
                state_next = ST_LVLB;
            end
            ST_LVLB: begin
                cmd.lvl_b  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (cmd.last) begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[hdl/mrms_dp.sv]
`timescale 1ns / 1ps
// mrms_dp: sums, frame counter, divider, square root, log2 and output word.
// Depends on mrms_pkg.
module mrms_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mrms_pkg::cmd_t                   cmd,
    output mrms_pkg::status_t                status,
    input  logic [mrms_pkg::ACT_BITS-1:0]    act,
    input  logic [7:0]                       contrast_c,
    input  logic [mrms_pkg::CH_BITS-1:0]     s_channel,
    input  logic signed [mrms_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [mrms_pkg::CH_BITS-1:0]     m_out_channel,
    output logic [mrms_pkg::SAMPLE_BITS-1:0] m_rms,
    output logic [7:0]                       m_level,
    output logic                             m_last
);

    logic [mrms_pkg::SUM_BITS-1:0]    sum_reg [mrms_pkg::NUM_CH];
    logic [mrms_pkg::COUNT_BITS-1:0]  frames_reg;
    logic [mrms_pkg::CH_BITS-1:0]     ch_in_reg;
    logic [mrms_pkg::SAMPLE_BITS-1:0] mag_reg;
    logic [mrms_pkg::SQ_BITS-1:0]     sq_reg;
    logic [mrms_pkg::DVD_BITS-1:0]    dvd_reg, q_reg;
    logic [mrms_pkg::COUNT_BITS-1:0]  rem_reg;
    logic [mrms_pkg::ROOT_BITS-1:0]   v_reg, res_reg, bit_reg;
    logic [mrms_pkg::SAMPLE_BITS-1:0] rms_reg;
    logic [30:0]                      m_reg;
    logic [4:0]                       e_reg;
    logic [15:0]                      frac_reg;
    logic [61:0]                      prod_reg;
    logic [34:0]                      p1_reg;
    logic [42:0]                      p2_reg;
    logic                             valid_reg;
    logic [mrms_pkg::CH_BITS-1:0]     och_reg;
    logic [mrms_pkg::SAMPLE_BITS-1:0] orms_reg;
    logic [7:0]                       olvl_reg;
    logic                             olast_reg;

    logic [mrms_pkg::SUM_BITS:0]      acc_sum;
    logic [mrms_pkg::COUNT_BITS:0]    div_try;
    logic                             div_ge;
    logic [mrms_pkg::ROOT_BITS-1:0]   trial;
    logic [31:0]                      frac_sq;
    logic [20:0]                      n_val;
    logic [43:0]                      lvl_round;
    logic [11:0]                      lvl_raw;
    logic [mrms_pkg::SAMPLE_BITS-1:0] r_clamp;
    logic                             in_use;
    logic [47:0]                      sq_full;

    assign sq_full = 48'(mag_reg) * 48'(mag_reg);
    assign acc_sum = {1'b0, sum_reg[ch_in_reg]} + (mrms_pkg::SUM_BITS + 1)'(sq_reg);
    assign in_use  = ({1'b0, ch_in_reg} < act);
    assign div_try = {rem_reg, dvd_reg[mrms_pkg::DVD_BITS-1]};
    assign div_ge  = (div_try >= {1'b0, frames_reg});
    assign trial   = res_reg + bit_reg;
    assign frac_sq = prod_reg[61:30];
    assign n_val   = 21'(23 << 16) - {e_reg, frac_reg};
    assign lvl_round = 44'(p2_reg) + (44'd1 << 31);
    assign lvl_raw = lvl_round[43:32];
    assign r_clamp = (rms_reg < mrms_pkg::RMS_LO) ? mrms_pkg::RMS_LO : rms_reg;

    // sums and frame count
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_all) begin
            for (int i = 0; i < mrms_pkg::NUM_CH; i++) sum_reg[i] <= '0;
            frames_reg <= '0;
        end else if (cmd.acc && in_use) begin
            sum_reg[ch_in_reg] <= acc_sum[mrms_pkg::SUM_BITS] ? '1
                                : acc_sum[mrms_pkg::SUM_BITS-1:0];
            if ({1'b0, ch_in_reg} == act - 1'b1 && frames_reg != '1)
                frames_reg <= frames_reg + 1'b1;
        end
    end

    // arithmetic payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_in_reg <= s_channel;
            mag_reg   <= s_sample[mrms_pkg::SAMPLE_BITS-1] ? (~s_sample + 1'b1) : s_sample;
        end
        if (cmd.square) sq_reg <= sq_full[47:16];
        if (cmd.div_init) begin
            dvd_reg <= {sum_reg[cmd.ch], 16'b0};
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? mrms_pkg::COUNT_BITS'(div_try - {1'b0, frames_reg})
                              : div_try[mrms_pkg::COUNT_BITS-1:0];
            q_reg   <= {q_reg[mrms_pkg::DVD_BITS-2:0], div_ge};
            dvd_reg <= {dvd_reg[mrms_pkg::DVD_BITS-2:0], 1'b0};
        end
        if (cmd.root_init) begin
            v_reg   <= q_reg[mrms_pkg::ROOT_BITS-1:0];
            res_reg <= '0;
            bit_reg <= mrms_pkg::ROOT_BITS'(1) << (mrms_pkg::ROOT_BITS - 2);
        end else if (cmd.root_step) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.rms_load) begin
            if (frames_reg == '0) rms_reg <= '0;
            else if (q_reg >= mrms_pkg::Q_OVF) rms_reg <= mrms_pkg::RMS_FULL;
            else if (res_reg > mrms_pkg::ROOT_BITS'(mrms_pkg::RMS_FULL))
                rms_reg <= mrms_pkg::RMS_FULL;
            else rms_reg <= res_reg[mrms_pkg::SAMPLE_BITS-1:0];
        end
        if (cmd.norm_init) begin
            m_reg    <= {r_clamp, 7'b0};
            e_reg    <= 5'd23;
            frac_reg <= '0;
        end else if (cmd.norm_step) begin
            m_reg <= {m_reg[29:0], 1'b0};
            e_reg <= e_reg - 1'b1;
        end else if (cmd.frac_upd) begin
            if (frac_sq[31]) begin
                m_reg    <= frac_sq[31:1];
                frac_reg <= {frac_reg[14:0], 1'b1};
            end else begin
                m_reg    <= frac_sq[30:0];
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end
        if (cmd.frac_mul) prod_reg <= 62'(m_reg) * 62'(m_reg);
        if (cmd.lvl_a) p1_reg <= 35'(n_val) * 35'(mrms_pkg::HALF_LOG10_2);
        if (cmd.lvl_b) p2_reg <= 43'(p1_reg) * 43'(contrast_c);
        if (cmd.out_load) begin
            och_reg   <= cmd.ch;
            orms_reg  <= rms_reg;
            olvl_reg  <= (lvl_raw > 12'(contrast_c)) ? contrast_c : lvl_raw[7:0];
            olast_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (cmd.out_load) valid_reg <= 1'b1;
        else if (m_ready) valid_reg <= 1'b0;
    end

    assign status.norm_done = m_reg[30];
    assign status.out_free  = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_out_channel = och_reg;
    assign m_rms         = orms_reg;
    assign m_level       = olvl_reg;
    assign m_last        = olast_reg;

endmodule

[hdl/multichannel_rms_meter.sv]
`timescale 1ns / 1ps
// multichannel_rms_meter: top level with APB register file, mrms_ctrl and mrms_dp.
// Depends on mrms_pkg, mrms_ctrl, mrms_dp.
//
//  port group   dir   words
//  s_*          in    sample or tick (opcode, channel, sample)
//  m_*          out   per-channel reading (out_channel, rms, level, last)
//  p*           in    APB config: 0x0 channels_in_use, 0x4 contrast
//
// Sample word: capture, 24x24 square, then saturating add into the sum.
// Tick word, per channel in use: the bit-serial divider (68 steps), the
//   square root (24 steps), normalize and the log2 squaring loop (32)
//   dominate. s_ready stays low meanwhile.
// Result register decouples m_ready: the next channel's reading is computed
//   while the previous one waits; a stall only holds the emit step.
// Reset (aresetn low, synchronous) clears sums, frame count, FSM and valids;
//   channels_in_use = 1, contrast = 128.
module multichannel_rms_meter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [mrms_pkg::CH_BITS-1:0]     s_channel,
    input  logic signed [mrms_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mrms_pkg::CH_BITS-1:0]     m_out_channel,
    output logic [mrms_pkg::SAMPLE_BITS-1:0] m_rms,
    output logic [7:0]                       m_level,
    output logic                             m_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [mrms_pkg::ACT_BITS-1:0] chan_reg;
    logic [7:0]                    contrast_reg;
    logic [mrms_pkg::ACT_BITS-1:0] act;
    logic [7:0]                    contrast_c;
    logic                          wr_en;
    mrms_pkg::cmd_t                cmd;
    mrms_pkg::status_t             status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg     <= 5'd1;
            contrast_reg <= 8'd128;
        end else if (wr_en) begin
            if (paddr[2] == mrms_pkg::REG_CHANNELS) chan_reg <= pwdata[4:0];
            else contrast_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == mrms_pkg::REG_CONTRAST) ? {24'b0, contrast_reg}
                                                         : {27'b0, chan_reg};

    // effective channel count 1..16 and contrast clamped to 26..230
    assign act = (chan_reg == '0) ? 5'd1
               : (chan_reg > 5'(mrms_pkg::NUM_CH)) ? 5'(mrms_pkg::NUM_CH) : chan_reg;
    assign contrast_c = (contrast_reg < mrms_pkg::C_MIN) ? mrms_pkg::C_MIN
                      : (contrast_reg > mrms_pkg::C_MAX) ? mrms_pkg::C_MAX : contrast_reg;

    mrms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .act      (act),
        .status   (status),
        .cmd      (cmd)
    );

    mrms_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .act           (act),
        .contrast_c    (contrast_c),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_channel (m_out_channel),
        .m_rms         (m_rms),
        .m_level       (m_level),
        .m_last        (m_last)
    );

    // a tick blocks new input words while the readout runs
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode |=> !s_ready)
        else $error("input accepted during readout");

    // the closing reading names the last channel in use
    a_last_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> ({1'b0, m_out_channel} == act - 1'b1))
        else $error("last flag on wrong channel");

    // level never exceeds the contrast scale
    a_level_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level <= contrast_c))
        else $error("level above contrast");

endmodule

[tb/multichannel_rms_meter_test.sv]
`timescale 1ns / 1ps
// multichannel_rms_meter_test: self-checking bench for the multichannel RMS meter.
// Depends on mrms_pkg and multichannel_rms_meter; predicts readings in a scoreboard class.

typedef struct packed {
    logic [3:0]  chan;
    logic [23:0] rms;
    logic [7:0]  level;
    logic        last;
} reading_t;

class meter_scoreboard;
    logic [51:0]  sums [16];
    logic [19:0]  frames;
    int unsigned  chans_reg;
    int unsigned  contrast_reg;
    reading_t     pending [$];
    int           errors;

    function void clear_state();
        foreach (sums[i]) sums[i] = '0;
        frames = '0;
        chans_reg = 1;
        contrast_reg = 128;
        errors = 0;
        pending.delete();
    endfunction

    function int unsigned active_count();
        int unsigned n;
        n = chans_reg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function logic [23:0] mean_root(logic [51:0] s, logic [19:0] f);
        logic [63:0] quot, rem, q, r;
        if (f == 0) return 0;
        quot = s / f;
        rem = s % f;
        if (quot > ((64'd1 << 46) >> 16)) return 24'h800000;
        q = (quot << 16) + ((rem << 16) / f);
        r = int_sqrt(q);
        return (r > 64'h800000) ? 24'h800000 : r[23:0];
    endfunction

    function logic [7:0] brightness(logic [23:0] rms);
        logic [63:0] c, r, m, frac, n, lvl;
        int unsigned e;
        c = contrast_reg;
        if (c < 26) c = 26;
        if (c > 230) c = 230;
        r = (rms < 24'd83886) ? 64'd83886 : rms;
        if (r > 64'h800000) r = 64'h800000;
        e = 0;
        for (int i = 0; i < 64; i++) if (r[i]) e = i;
        m = (e <= 30) ? (r << (30 - e)) : (r >> (e - 30));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        n = (64'd23 << 16) - ((64'(e) << 16) | frac);
        lvl = (n * 64'd9864 * c + (64'd1 << 31)) >> 32;
        return (lvl > c) ? c[7:0] : lvl[7:0];
    endfunction

    // note an accepted input word
    function void note_word(logic op, logic [3:0] ch, logic [23:0] smp);
        int unsigned act;
        logic [63:0] mag, sq, room;
        reading_t rd;
        act = active_count();
        if (op == 1'b0) begin
            if (ch >= act) return;
            mag = smp[23] ? (64'h1000000 - smp) : smp;
            sq = (mag * mag) >> 16;
            room = 64'hF_FFFF_FFFF_FFFF - sums[ch];
            if (sq > room) sums[ch] = '1;
            else sums[ch] = sums[ch] + sq;
            if (ch == act - 1 && frames != '1) frames = frames + 1;
        end else begin
            for (int unsigned k = 0; k < act; k++) begin
                rd.chan = k[3:0];
                rd.rms = mean_root(sums[k], frames);
                rd.level = brightness(rd.rms);
                rd.last = (k == act - 1);
                pending.push_back(rd);
            end
            foreach (sums[i]) sums[i] = '0;
            frames = '0;
        end
    endfunction

    function void check_reading(reading_t got);
        reading_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected reading ch=%0d rms=%0d", $time, got.chan, got.rms);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.chan !== want.chan)
            $display("%0t: out_channel exp %0d got %0d", $time, want.chan, got.chan);
        if (got.rms !== want.rms)
            $display("%0t: rms exp %0d got %0d", $time, want.rms, got.rms);
        if (got.level !== want.level)
            $display("%0t: level exp %0d got %0d", $time, want.level, got.level);
        if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
        if (got !== want) errors++;
    endfunction
endclass

module multichannel_rms_meter_test;

    localparam logic [2:0] ADDR_CHANNELS = 3'h0;
    localparam logic [2:0] ADDR_CONTRAST = 3'h4;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_opcode = 1'b0;
    logic [mrms_pkg::CH_BITS-1:0]     s_channel = '0;
    logic [mrms_pkg::SAMPLE_BITS-1:0] s_sample = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [mrms_pkg::CH_BITS-1:0]     m_out_channel;
    logic [mrms_pkg::SAMPLE_BITS-1:0] m_rms;
    logic [7:0]                       m_level;
    logic                             m_last;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [2:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    meter_scoreboard readings = new();
    int stall_mode = 0;   // 0: always ready, 1: random stalls, 2: long stalls

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    multichannel_rms_meter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_channel(s_channel), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_channel(m_out_channel),
        .m_rms(m_rms), .m_level(m_level), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Receiver: sample at the edge, then pick next m_ready per stall mode.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            readings.check_reading('{m_out_channel, m_rms, m_level, m_last});
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Setup then access phase; register is updated at the access edge.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_CHANNELS) readings.chans_reg = value[4:0];
        else readings.contrast_reg = value[7:0];
    endtask

    // Present one word and hold it until accepted.
    task automatic send_word(logic op, logic [3:0] ch, logic [23:0] smp);
        s_valid <= 1'b1; s_opcode <= op; s_channel <= ch; s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        readings.note_word(op, ch, smp);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Block until all readings are in; extra cycles cover an in-flight sample.
    task automatic drain();
        idle_sender(1);
        while (readings.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Mostly full frames of random samples, plus stray words and ticks.
    task automatic random_phase(int words);
        int unsigned act, burst, sent;
        logic [23:0] smp;
        sent = 0;
        burst = 0;
        while (sent < words) begin
            act = readings.active_count();
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
            end
            case ($urandom_range(0, 9))
                0: begin
                    send_word(OP_TICK, 4'($urandom), 24'($urandom));
                    sent++;
                end
                1: begin
                    send_word(OP_SAMPLE, 4'($urandom), 24'($urandom));
                    sent++;
                end
                default: begin
                    for (int unsigned k = 0; k < act && sent < words; k++) begin
                        case ($urandom_range(0, 5))
                            0: smp = 24'h800000;
                            1: smp = 24'h7FFFFF;
                            default: smp = 24'($urandom);
                        endcase
                        send_word(OP_SAMPLE, k[3:0], smp);
                        sent++;
                    end
                end
            endcase
            burst--;
        end
        send_word(OP_TICK, '0, '0);
    endtask

    initial begin
        readings.clear_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: tick with no frames, field extremes, ignored channel.
        send_word(OP_TICK, 4'hF, 24'hFFFFFF);
        send_word(OP_SAMPLE, 4'h0, 24'h800000);
        send_word(OP_SAMPLE, 4'h5, 24'h7FFFFF);
        send_word(OP_TICK, '0, '0);
        send_word(OP_SAMPLE, 4'h0, 24'h000001);
        send_word(OP_SAMPLE, 4'h0, 24'hFFFFFF);
        send_word(OP_TICK, '0, '0);
        drain();
        write_reg(ADDR_CHANNELS, 32'd16);
        write_reg(ADDR_CONTRAST, 32'd230);
        for (int k = 0; k < 16; k++)
            send_word(OP_SAMPLE, k[3:0], (k[0]) ? 24'h800000 : 24'h00A3D7);
        send_word(OP_TICK, '0, '0);
        drain();
        write_reg(ADDR_CHANNELS, 32'd0);    // acts as one
        write_reg(ADDR_CONTRAST, 32'd0);    // clamps up
        send_word(OP_SAMPLE, 4'h0, 24'h555555);
        send_word(OP_TICK, '0, '0);
        drain();
        write_reg(ADDR_CHANNELS, 32'd31);   // clamps to sixteen
        write_reg(ADDR_CONTRAST, 32'd255);  // clamps down
        send_word(OP_SAMPLE, 4'hF, 24'hAAAAAA);
        send_word(OP_TICK, '0, '0);
        drain();

        // Random phases across settings and receiver modes.
        for (int ph = 0; ph < 6; ph++) begin
            stall_mode = ph % 3;
            write_reg(ADDR_CHANNELS, (ph == 0) ? 32'd1 : $urandom_range(1, 16));
            write_reg(ADDR_CONTRAST, (ph == 1) ? 32'd26 : $urandom_range(26, 230));
            random_phase(70);
            drain();
        end

        drain();
        if (readings.errors == 0 && readings.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
